>>> design/byte_mixing_hash_256_macros.svh
// Assertion macros for the byte mixing hash.
// Used by the top level; relies on a clock named clk and a reset named rst in scope.
`ifndef BYTE_MIXING_HASH_256_MACROS_SVH
`define BYTE_MIXING_HASH_256_MACROS_SVH

// same-cycle implication
`define BMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmh check failed");

// next-cycle implication
`define BMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmh check failed");

`endif

>>> design/bmh_pkg.sv
// Shared types, constants and functions for the byte mixing hash.
// No dependencies.
`default_nettype none

package bmh_pkg;

  localparam int WORDS       = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef logic [WORDS-1:0][31:0] word_arr_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam word_arr_t INIT_WORDS = {
    32'o544766072,  32'o740324712,  32'd1768384628, 32'd1869573740,
    32'd1747722349, 32'd1949048949, 32'd1818847080, 32'd1399877492
  };

  typedef struct packed {
    logic        finish;
    logic [2:0]  pos;
    logic [31:0] mixed;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) begin
      r[k] = v[31-k];
    end
    return r;
  endfunction

  // four folding rounds
  function automatic word_arr_t fold(input word_arr_t w);
    word_arr_t h;
    h = w;
    for (int r = 0; r < 4; r++) begin
      h[4+r] = h[4+r] ^ h[r];
      h[r+1] = h[r+1] ^ h[r+4];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> design/bmh_msg_if.sv
// Input channel: command, message byte and message length.
// No dependencies.
`default_nettype none

interface bmh_msg_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  data_byte;
  logic [31:0] message_length;

  modport source (output valid, command, data_byte, message_length, input ready);
  modport sink   (input valid, command, data_byte, message_length, output ready);
endinterface

`default_nettype wire

>>> design/bmh_digest_if.sv
// Output channel: digest words with a last-word flag.
// No dependencies.
`default_nettype none

interface bmh_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, digest_word, last_word, input ready);
  modport sink   (input valid, digest_word, last_word, output ready);
endinterface

`default_nettype wire

>>> design/byte_mixing_hash_256.sv
// Top level of the byte mixing hash: front, queue and back joined.
// Depends on bmh_pkg, bmh_msg_if, bmh_digest_if, bmh_front, bmh_queue, bmh_back.
//
//   channel  role    payload                                 transfer
//   msg      sink    command, data_byte, message_length      valid & ready
//   digest   source  digest_word, last_word                  valid & ready
//
// One message item per cycle is taken while the queue has room; the back
// applies one absorb per cycle. A finish yields eight words, one word per digest
// transfer; absorbs of the next message continue meanwhile. Reset (rst, synchronous)
// reloads the initial words at once.
// A stalled digest fills the queue after a further finish, then msg.ready drops.
`default_nettype none

module byte_mixing_hash_256 #(
  parameter int QUEUE_DEPTH = bmh_pkg::QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  bmh_msg_if.sink        msg,
  bmh_digest_if.source   digest
);

`include "byte_mixing_hash_256_macros.svh"

  bmh_pkg::op_t          push_op;
  bmh_pkg::op_t          head_op;
  bmh_pkg::queue_status_t q_status;
  logic                  push;
  logic                  pop;
  logic                  last_xfer;

  bmh_front u_front (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .q_full (q_status.full),
    .op     (push_op),
    .push   (push)
  );

  bmh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_op  (push_op),
    .pop    (pop),
    .rd_op  (head_op),
    .status (q_status)
  );

  bmh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (head_op),
    .op_valid (!q_status.empty),
    .pop      (pop),
    .digest   (digest)
  );

  assign last_xfer = digest.valid && digest.ready && digest.last_word;

  `BMH_ASSERT_NOW(a_full_blocks_input, q_status.full, !msg.ready)
  `BMH_ASSERT_NOW(a_pop_not_empty, pop, !q_status.empty)
  `BMH_ASSERT_NEXT(a_last_then_fresh, last_xfer, !digest.last_word)

endmodule

`default_nettype wire

>>> design/bmh_front.sv
// Front end: takes message items, keeps running sum and word position,
// computes the mixed value of each byte. Depends on bmh_pkg, bmh_msg_if.
`default_nettype none

module bmh_front (
  input  wire logic           clk,
  input  wire logic           rst,
  bmh_msg_if.sink             msg,
  input  wire logic           q_full,
  output bmh_pkg::op_t        op,
  output logic                push
);

  logic [31:0] running_sum;
  logic [2:0]  word_position;
  logic [31:0] ext;
  logic [31:0] sum_next;
  logic [31:0] amount;

  assign msg.ready = !q_full;
  assign push      = msg.valid && !q_full;

  always_comb begin
    ext       = {{24{msg.data_byte[7]}}, msg.data_byte};
    sum_next  = running_sum + ext;
    amount    = ext + sum_next + msg.message_length;
    op.finish = (msg.command == bmh_pkg::CMD_FINISH);
    op.pos    = word_position;
    op.mixed  = (bmh_pkg::rev32(ext) >> amount[3:0]) ^ (ext << amount[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      word_position <= '0;
    end else if (push) begin
      if (op.finish) begin
        running_sum   <= '0;
        word_position <= '0;
      end else begin
        running_sum   <= sum_next;
        word_position <= word_position + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/bmh_queue.sv
// Short queue of classified operations between front and back.
// Depends on bmh_pkg.
`default_nettype none

module bmh_queue #(
  parameter int DEPTH = bmh_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bmh_pkg::op_t   wr_op,
  input  wire logic           pop,
  output bmh_pkg::op_t        rd_op,
  output bmh_pkg::queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bmh_pkg::op_t  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign rd_op        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/bmh_back.sv
// Back end: owns the hash words, applies absorbs, folds on finish and
// streams the eight digest words. Depends on bmh_pkg, bmh_digest_if.
`default_nettype none

module bmh_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bmh_pkg::op_t   op,
  input  wire logic           op_valid,
  output logic                pop,
  bmh_digest_if.source        digest
);

  bmh_pkg::word_arr_t hash_words;
  bmh_pkg::word_arr_t folded;
  logic [31:0]        dig [5];
  logic               busy;
  logic [2:0]         idx;
  logic [3:0]         idx_inc;
  logic               xfer;
  logic               last_xfer;

  assign idx_inc            = {1'b0, idx} + 4'd1;
  assign digest.valid       = busy;
  assign digest.digest_word = dig[idx_inc[3:1]];
  assign digest.last_word   = (idx == 3'd7);

  assign xfer      = busy && digest.ready;
  assign last_xfer = xfer && (idx == 3'd7);
  assign pop       = op_valid && (!op.finish || !busy || last_xfer);
  assign folded    = bmh_pkg::fold(hash_words);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_words <= bmh_pkg::INIT_WORDS;
    end else if (pop) begin
      if (op.finish) begin
        hash_words <= bmh_pkg::INIT_WORDS;
      end else begin
        hash_words[op.pos] <= hash_words[op.pos] ^ op.mixed;
      end
    end
  end

  // digest holds h0..h4 after folding; output order h0 h1 h1 h2 h2 h3 h3 h4
  always_ff @(posedge clk) begin
    if (pop && op.finish) begin
      for (int k = 0; k < 5; k++) begin
        dig[k] <= folded[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop && op.finish) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_mixing_hash_256: drives message items and checks digest words.
// Depends on bmh_pkg, bmh_msg_if, bmh_digest_if and the byte_mixing_hash_256 RTL.

module tb_top;

  localparam int RANDOM_ITEMS   = 70;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 24;

  localparam logic [31:0] SEED_WORDS [8] = '{
    32'd1399877492, 32'd1818847080, 32'd1949048949, 32'd1747722349,
    32'd1869573740, 32'd1768384628, 32'o740324712,  32'o544766072
  };

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_t;

  typedef enum {LEN_EXACT, LEN_OTHER, LEN_WANDER} len_mode_t;

  logic clk;
  logic rst;

  logic [31:0] hash_state [8];
  logic [31:0] byte_sum;
  logic [2:0]  next_slot;
  digest_t     expected_words[$];

  int fail_count;
  int items_sent;
  int quiet_cycles;
  bit src_idle_on;
  bit sink_stall_on;

  bmh_msg_if    msg_ch();
  bmh_digest_if digest_ch();

  byte_mixing_hash_256 u_top (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .digest (digest_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reload_state();
    for (int k = 0; k < 8; k++) begin
      hash_state[k] = SEED_WORDS[k];
    end
    byte_sum  = '0;
    next_slot = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b, input logic [31:0] len);
    logic [31:0] ext;
    logic [31:0] shift_sel;
    logic [31:0] flipped;
    logic [31:0] mixed;
    ext = {{24{b[7]}}, b};
    byte_sum = byte_sum + ext;
    shift_sel = ext + byte_sum + len;
    for (int k = 0; k < 32; k++) begin
      flipped[31-k] = ext[k];
    end
    mixed = (flipped >> shift_sel[3:0]) ^ (ext << shift_sel[4:0]);
    hash_state[next_slot] = hash_state[next_slot] ^ mixed;
    next_slot = next_slot + 3'd1;
  endfunction

  function automatic void fold_and_emit();
    for (int r = 0; r < 4; r++) begin
      hash_state[4+r] = hash_state[4+r] ^ hash_state[r];
      hash_state[r+1] = hash_state[r+1] ^ hash_state[r+4];
      expected_words.push_back('{word: hash_state[r], last: 1'b0});
      expected_words.push_back('{word: hash_state[r+1], last: (r == 3)});
    end
    reload_state();
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // predict on every accepted message transfer
  always @(posedge clk) begin
    if (!rst && msg_ch.valid && msg_ch.ready) begin
      if (msg_ch.command == bmh_pkg::CMD_FINISH) begin
        fold_and_emit();
      end else begin
        absorb_byte(msg_ch.data_byte, msg_ch.message_length);
      end
    end
  end

  always @(posedge clk) begin : digest_check
    digest_t want;
    if (!rst && digest_ch.valid && digest_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected digest transfer: digest_word %h last_word %b",
               digest_ch.digest_word, digest_ch.last_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (digest_ch.digest_word !== want.word) begin
          $error("digest_word: expected %h, actual %h", want.word, digest_ch.digest_word);
          fail_count++;
        end
        if (digest_ch.last_word !== want.last) begin
          $error("last_word: expected %b, actual %b", want.last, digest_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (digest_ch.valid && digest_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // digest sink back-pressure
  initial begin
    int n;
    digest_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (sink_stall_on) begin
        n = pick_gap();
        if (n > 0) begin
          digest_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        digest_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        digest_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] b, input logic [31:0] len);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid          <= 1'b1;
    msg_ch.command        <= cmd;
    msg_ch.data_byte      <= b;
    msg_ch.message_length <= len;
    @(posedge clk);
    while (!msg_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(input int n_bytes, input len_mode_t mode);
    logic [31:0] len;
    len = (mode == LEN_EXACT) ? n_bytes : $urandom();
    for (int i = 0; i < n_bytes; i++) begin
      if (mode == LEN_WANDER) len = $urandom();
      send_item(bmh_pkg::CMD_ABSORB, 8'($urandom_range(0, 255)), len);
    end
    send_item(bmh_pkg::CMD_FINISH, 8'($urandom_range(0, 255)), len);
  endtask

  task automatic test_empty_finish();
    send_item(bmh_pkg::CMD_FINISH, 8'h00, 32'd0);
    send_item(bmh_pkg::CMD_FINISH, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_byte_extremes();
    logic [7:0] edge_bytes [6] = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'hFE};
    foreach (edge_bytes[i]) send_item(bmh_pkg::CMD_ABSORB, edge_bytes[i], 32'd6);
    send_item(bmh_pkg::CMD_FINISH, 8'h00, 32'd6);
    send_item(bmh_pkg::CMD_ABSORB, 8'h80, 32'hFFFF_FFFF);
    send_item(bmh_pkg::CMD_ABSORB, 8'hFF, 32'hFFFF_FFFF);
    send_item(bmh_pkg::CMD_FINISH, 8'hFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_length_quirks();
    // length disagrees with byte count, then changes from byte to byte
    send_item(bmh_pkg::CMD_ABSORB, 8'h5A, 32'd0);
    send_item(bmh_pkg::CMD_ABSORB, 8'hA5, 32'd0);
    send_item(bmh_pkg::CMD_ABSORB, 8'hC3, 32'd0);
    send_item(bmh_pkg::CMD_FINISH, 8'h3C, 32'd0);
    send_item(bmh_pkg::CMD_ABSORB, 8'h11, 32'd1);
    send_item(bmh_pkg::CMD_ABSORB, 8'h92, 32'h8000_0000);
    send_item(bmh_pkg::CMD_ABSORB, 8'hE7, 32'h5555_AAAA);
    send_item(bmh_pkg::CMD_FINISH, 8'h00, 32'hAAAA_5555);
  endtask

  task automatic test_back_to_back();
    src_idle_on   = 1'b0;
    sink_stall_on = 1'b0;
    send_message(8, LEN_EXACT);
    send_message(0, LEN_EXACT);
    send_message(0, LEN_OTHER);
    send_message(5, LEN_EXACT);
    // stalled sink with a full-rate source fills the queue
    sink_stall_on = 1'b1;
    send_message(3, LEN_EXACT);
    send_message(0, LEN_EXACT);
    send_message(0, LEN_EXACT);
    send_message(2, LEN_WANDER);
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_messages();
    int target;
    int roll;
    int n;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      src_idle_on   = ($urandom_range(0, 3) != 0);
      sink_stall_on = ($urandom_range(0, 3) != 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 12);
      roll = $urandom_range(0, 9);
      if (roll < 8) send_message(n, LEN_EXACT);
      else if (roll == 8) send_message(n, LEN_OTHER);
      else send_message(n, LEN_WANDER);
    end
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  initial begin
    rst                   <= 1'b1;
    msg_ch.valid          <= 1'b0;
    msg_ch.command        <= bmh_pkg::CMD_ABSORB;
    msg_ch.data_byte      <= '0;
    msg_ch.message_length <= '0;
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    fail_count    = 0;
    items_sent    = 0;
    quiet_cycles  = 0;
    reload_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_empty_finish();
    test_byte_extremes();
    test_length_quirks();
    test_back_to_back();
    test_random_messages();

    msg_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
